@@ sv/keyed_block_transposition_cipher_defines.svh @@
// assertion macros used by the checker file
`ifndef KEYED_BLOCK_TRANSPOSITION_CIPHER_DEFINES_SVH
`define KEYED_BLOCK_TRANSPOSITION_CIPHER_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define KBTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also watches the reset cycles
`define KBTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/kbtc_pkg.sv @@
// shared types and constants of the keyed block transposition cipher
`timescale 1ns / 1ps

package kbtc_pkg;

  // default longest key, also the store depth
  localparam int MAX_KEY_LEN_DEF = 8;
  // step counter width, enough for any key length up to eight
  localparam int STEP_W = 3;

  localparam int KEY_W = 64;
  localparam int LEN_W = 4;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 2'd2;

  // reset key "abcd", first character in the lowest byte
  localparam logic [KEY_W-1:0] KEY_CHARS_RESET  = 64'h0000_0000_6463_6261;
  localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = 4'd4;

  localparam logic [7:0] PAD_CHAR  = 8'h30;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       run_last;
    logic       message_end;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              rank_step;
    logic              emit_step;
    logic [STEP_W-1:0] idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rerank;
    logic need_emit;
    logic last_rank;
    logic last_emit;
    logic out_free;
  } status_t;

endpackage

@@ sv/keyed_block_transposition_cipher.sv @@
// top level of the keyed block transposition cipher
`timescale 1ns / 1ps

// Keyed block transposition cipher. Message bytes arrive one per request and
// are gathered into a block as long as the key (key_len, clamped to
// 1..MAX_KEY_LEN). A printable byte (32..126) is stored; any other byte closes
// the message and is dropped. A full block, a printable byte flagged
// end_of_message, or a closing byte sends the block out, padded with '0',
// one character per result: encrypt gives block[rank[j]], decrypt puts block[j]
// at slot rank[j], where rank[j] is key character j's place in ascending byte
// order, ties to the lower index. A closing byte on an empty block gives one
// marker result with has_symbol low. A request that causes no result is simply
// taken; one that does is taken and then occupies the block while the emission
// counter walks the block store, one result per block character (or one for a
// marker), pausing while the result side stalls. A result register sits on the
// output, so the next request is taken while the last result still waits.
// Writing key_chars or key_len while idle starts a ranking pass over the block
// characters, during which requests are held off; direction takes effect at
// the next emission step.
module keyed_block_transposition_cipher import kbtc_pkg::*; #(
  parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  // message requests
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req_data,
  // permuted characters
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res_data
);

  cmd_t    cmd;
  status_t status;

  // sequencer: intake, ranking pass, emission walk
  kbtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // key, rank tables, block store and result register
  kbtc_datapath #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_data  (req_data),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

@@ sv/kbtc_ctrl.sv @@
// sequencer for request intake, key ranking and block emission
`timescale 1ns / 1ps

module kbtc_ctrl import kbtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RANK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] idx, idx_next;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready  = !status.rerank;
        cmd.accept = req_valid && !status.rerank;
        if (status.rerank) begin
          state_next = ST_RANK;
          idx_next   = '0;
        end else if (req_valid && status.need_emit) begin
          state_next = ST_EMIT;
          idx_next   = '0;
        end
      end
      ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (status.last_rank) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = STEP_W'(idx + 1'b1);
        end
      end
      ST_EMIT: begin
        cmd.emit_step = status.out_free;
        if (status.out_free) begin
          if (status.last_emit) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = STEP_W'(idx + 1'b1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

@@ sv/kbtc_datapath.sv @@
// key registers, rank tables, block store and result register
`timescale 1ns / 1ps

module kbtc_datapath import kbtc_pkg::*; #(
  parameter int MAX_KEY_LEN = MAX_KEY_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  req_t                 req_data,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res_data
);

  localparam int IDX_W  = $clog2(MAX_KEY_LEN);
  localparam int FILL_W = $clog2(MAX_KEY_LEN + 1);
  localparam int RESET_N = (int'(KEY_LENGTH_RESET) > MAX_KEY_LEN) ?
                           MAX_KEY_LEN : int'(KEY_LENGTH_RESET);

  logic [KEY_W-1:0]  key_chars;
  logic [LEN_W-1:0]  key_len;
  logic              direction;

  logic [7:0]        block_store [MAX_KEY_LEN];
  logic [IDX_W-1:0]  rank_tab    [MAX_KEY_LEN];
  logic [IDX_W-1:0]  inv_tab     [MAX_KEY_LEN];
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] emit_fill;
  logic              emit_msg_end;
  logic              emit_marker;

  logic [7:0]        key_byte [MAX_KEY_LEN];
  logic [FILL_W-1:0] blk_len, blk_len_m1, fill_inc, sel_ext;
  logic [IDX_W-1:0]  pos, rank_val, sel;
  logic [MAX_KEY_LEN-1:0] below;
  logic              printable;
  res_t              res_next;

  for (genvar k = 0; k < MAX_KEY_LEN; k++) begin : g_key
    assign key_byte[k] = key_chars[8*k +: 8];
  end

  // block length, clamped to 1..MAX_KEY_LEN
  always_comb begin
    if (key_len == '0) begin
      blk_len = FILL_W'(1);
    end else if (key_len > LEN_W'(MAX_KEY_LEN)) begin
      blk_len = FILL_W'(MAX_KEY_LEN);
    end else begin
      blk_len = FILL_W'(key_len);
    end
  end

  assign blk_len_m1 = FILL_W'(blk_len - 1'b1);
  assign pos        = cmd.idx[IDX_W-1:0];
  assign printable  = (req_data.symbol >= PRINT_LO) && (req_data.symbol <= PRINT_HI);
  assign fill_inc   = FILL_W'(fill_count + 1'b1);

  // rank of key character pos: how many key characters sort ahead of it
  always_comb begin
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      below[k] = (FILL_W'(k) < blk_len) &&
                 ((key_byte[k] < key_byte[pos]) ||
                  ((key_byte[k] == key_byte[pos]) && (IDX_W'(k) < pos)));
    end
    rank_val = IDX_W'($countones(below));
  end

  // source position of output slot pos, padding read as '0'
  always_comb begin
    sel = direction ? inv_tab[pos] : rank_tab[pos];
    if (FILL_W'(sel) >= blk_len) begin
      sel = blk_len_m1[IDX_W-1:0];
    end
    sel_ext = FILL_W'(sel);
    res_next.has_symbol  = !emit_marker;
    res_next.out_symbol  = emit_marker ? 8'd0 :
                           ((sel_ext >= emit_fill) ? PAD_CHAR : block_store[sel]);
    res_next.run_last    = status.last_emit;
    res_next.message_end = status.last_emit && emit_msg_end;
  end

  always_comb begin
    status.rerank    = cfg_write &&
                       ((cfg_index == REG_KEY_CHARS) || (cfg_index == REG_KEY_LENGTH));
    status.need_emit = printable ? ((fill_inc >= blk_len) || req_data.end_of_message)
                                 : 1'b1;
    status.last_rank = (FILL_W'(cmd.idx) == blk_len_m1);
    status.last_emit = emit_marker || (FILL_W'(cmd.idx) == blk_len_m1);
    status.out_free  = !res_valid || res_ready;
  end

  // configuration registers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars  <= KEY_CHARS_RESET;
      key_len    <= KEY_LENGTH_RESET;
      direction  <= 1'b0;
      fill_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_KEY_CHARS:  key_chars <= cfg_data;
          REG_KEY_LENGTH: begin
            key_len    <= cfg_data[LEN_W-1:0];
            fill_count <= '0;
          end
          REG_DIRECTION:  direction <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (printable && !status.need_emit) begin
          fill_count <= fill_inc;
        end else begin
          fill_count <= '0;
        end
      end
    end
  end

  // details of the pending emission
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      emit_fill    <= printable ? fill_inc : fill_count;
      emit_msg_end <= printable ? req_data.end_of_message : 1'b1;
      emit_marker  <= !printable && (fill_count == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && printable) begin
      block_store[fill_count[IDX_W-1:0]] <= req_data.symbol;
    end
  end

  // the reset key is in ascending order, so its ranks are the identity
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        rank_tab[j] <= (j < RESET_N) ? IDX_W'(j) : '0;
        inv_tab[j]  <= (j < RESET_N) ? IDX_W'(j) : '0;
      end
    end else if (cmd.rank_step) begin
      rank_tab[pos]     <= rank_val;
      inv_tab[rank_val] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      res_data <= res_next;
    end
  end

endmodule

@@ sv/kbtc_checker.sv @@
// port-level checks on the cipher, bound to the top level
`timescale 1ns / 1ps
`include "keyed_block_transposition_cipher_defines.svh"

module kbtc_checker import kbtc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // a stalled result holds
  `KBTC_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "result changed while stalled")

  // marker carries no character and closes both the run and the message
  `KBTC_ASSERT(a_marker_form, res_valid && !res_data.has_symbol |-> res_data.run_last && res_data.message_end && (res_data.out_symbol == 8'd0), "malformed marker")

  // message end only on the last result of a run, characters always printable
  `KBTC_ASSERT(a_end_is_last, res_valid && res_data.message_end |-> res_data.run_last, "message end before run end")
  `KBTC_ASSERT(a_printable_out, res_valid && res_data.has_symbol |-> (res_data.out_symbol >= PRINT_LO) && (res_data.out_symbol <= PRINT_HI), "unprintable character out")

  // reset empties the result register
  `KBTC_ASSERT_ALWAYS(a_reset_empty, rst |=> !res_valid, "result valid after reset")

endmodule

bind keyed_block_transposition_cipher kbtc_checker u_kbtc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

@@ tb/keyed_block_transposition_cipher_test.sv @@
// self-checking testbench for the keyed block transposition cipher
`timescale 1ns / 1ps

module keyed_block_transposition_cipher_test;
  import kbtc_pkg::*;

  localparam int HALF_PERIOD = 4;
  localparam int CLK_PERIOD = 2 * HALF_PERIOD;
  localparam int RESET_CYCLES = 7;
  // a full emission plus a ranking pass, with some margin
  localparam int SETTLE_CYCLES = 2 * MAX_KEY_LEN_DEF + 4;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int LAPS = 10;
  localparam int ITEMS_PER_LAP = 28;

  // index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] CLOSE_BYTE = 8'h0a;

  // closing byte on an empty block
  localparam res_t CLOSE_MARKER = {8'h00, 1'b0, 1'b1, 1'b1};

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [KEY_W-1:0]     data;
    req_t                 req;
    bit                   typed;
    res_t                 want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req_data = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_t                 res_data;

  keyed_block_transposition_cipher uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // mirror of the block: key, length as written, direction, gathered characters
  logic [KEY_W-1:0] key_now;
  logic [LEN_W-1:0] len_now;
  logic             dir_now;
  logic [7:0]       block_chars [MAX_KEY_LEN_DEF];
  int unsigned      held;
  logic [2:0]       place [MAX_KEY_LEN_DEF];

  // characters one request gives, and all characters still owed
  res_t step_chars [MAX_KEY_LEN_DEF];
  int   step_count;
  res_t expected_chars [$];

  plan_row_t plan [$];
  res_t      oldest;
  bit        quiet_spell = 1'b0;
  int        mismatches = 0;
  int        requests_sent = 0;
  int        results_seen = 0;
  int        writes_done = 0;

  function automatic int unsigned block_len();
    int unsigned n;
    n = len_now;
    if (n < 1) n = 1;
    if (n > MAX_KEY_LEN_DEF) n = MAX_KEY_LEN_DEF;
    return n;
  endfunction

  // rank of each key character in ascending byte order, ties to the lower index
  function automatic void rank_key();
    int unsigned n;
    int unsigned r;
    n = block_len();
    for (int j = 0; j < MAX_KEY_LEN_DEF; j++) place[j] = '0;
    for (int j = 0; j < n; j++) begin
      r = 0;
      for (int k = 0; k < n; k++) begin
        if (key_now[k*8 +: 8] < key_now[j*8 +: 8] ||
            (key_now[k*8 +: 8] == key_now[j*8 +: 8] && k < j)) r++;
      end
      place[j] = r[2:0];
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [KEY_W-1:0] data);
    case (idx)
      REG_KEY_CHARS: begin
        key_now = data;
        rank_key();
      end
      REG_KEY_LENGTH: begin
        len_now = data[LEN_W-1:0];
        held = 0;
        rank_key();
      end
      REG_DIRECTION: begin
        dir_now = data[0];
      end
      default: ;
    endcase
  endfunction

  // pad with '0' and permute the block into step_chars
  function automatic void emit_permuted(input bit closes);
    int unsigned n;
    int unsigned r;
    logic [7:0]  order [MAX_KEY_LEN_DEF];
    n = block_len();
    for (int j = held; j < n; j++) block_chars[j] = PAD_CHAR;
    for (int j = 0; j < n; j++) begin
      r = place[j];
      if (r >= n) r = n - 1;
      if (!dir_now) order[j] = block_chars[r];
      else order[r] = block_chars[j];
    end
    for (int j = 0; j < n; j++) begin
      step_chars[j].out_symbol  = order[j];
      step_chars[j].has_symbol  = 1'b1;
      step_chars[j].run_last    = (j == n - 1);
      step_chars[j].message_end = (j == n - 1) && closes;
    end
    step_count = n;
    held = 0;
  endfunction

  function automatic void cipher_step(input req_t r);
    int unsigned n;
    n = block_len();
    step_count = 0;
    if (r.symbol >= PRINT_LO && r.symbol <= PRINT_HI) begin
      if (held >= n) held = 0;
      block_chars[held] = r.symbol;
      held++;
      if (held >= n || r.end_of_message) emit_permuted(r.end_of_message);
    end else if (held > 0) begin
      if (held > n) held = n;
      emit_permuted(1'b1);
    end else begin
      step_chars[0] = CLOSE_MARKER;
      step_count = 1;
    end
  endfunction

  function automatic plan_row_t item_row(input logic [7:0] s, input logic e,
                                         input bit typed = 1'b0, input res_t want = '0);
    plan_row_t row;
    row.is_write = 1'b0;
    row.idx      = '0;
    row.data     = '0;
    row.req      = {s, e};
    row.typed    = typed;
    row.want     = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [KEY_W-1:0] data);
    plan_row_t row;
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    row.req      = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    return row;
  endfunction

  // one request after a random gap; expectations are queued at acceptance
  task automatic send_request(input req_t r, input bit typed = 1'b0, input res_t want = '0);
    int gap;
    gap = quiet_spell ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    requests_sent++;
    cipher_step(r);
    if (typed) expected_chars.push_back(want);
    else for (int j = 0; j < step_count; j++) expected_chars.push_back(step_chars[j]);
  endtask

  // hold requests back until every owed character is out and the block is quiet
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_register(idx, data);
    writes_done++;
  endtask

  // result side: a fresh stall for every character
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      stall = quiet_spell ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // every accepted character against the oldest one owed
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_chars.size() == 0) begin
        $error("character with nothing owed: %h", res_data);
        mismatches++;
      end else begin
        oldest = expected_chars.pop_front();
        results_seen++;
        if (res_data.out_symbol !== oldest.out_symbol) begin
          $error("out_symbol: expected %h, got %h", oldest.out_symbol, res_data.out_symbol);
          mismatches++;
        end
        if (res_data.has_symbol !== oldest.has_symbol) begin
          $error("has_symbol: expected %b, got %b", oldest.has_symbol, res_data.has_symbol);
          mismatches++;
        end
        if (res_data.run_last !== oldest.run_last) begin
          $error("run_last: expected %b, got %b", oldest.run_last, res_data.run_last);
          mismatches++;
        end
        if (res_data.message_end !== oldest.message_end) begin
          $error("message_end: expected %b, got %b", oldest.message_end,
                 res_data.message_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timed out with %0d characters still owed", expected_chars.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned      roll;
    int               lap_items;
    logic [KEY_W-1:0] fill;
    logic [LEN_W-1:0] len_pick;
    req_t             r;

    // directed rows: reset key "abcd" keeps the block order for the first ones
    plan.push_back(item_row(8'h00, 1'b0, 1'b1, CLOSE_MARKER));
    plan.push_back(item_row("A", 1'b0));
    plan.push_back(item_row("B", 1'b0));
    plan.push_back(item_row("C", 1'b0));
    plan.push_back(item_row("D", 1'b0));
    plan.push_back(item_row(PRINT_LO, 1'b1));
    plan.push_back(item_row(PRINT_HI, 1'b0));
    plan.push_back(item_row(8'hff, 1'b1));
    plan.push_back(item_row(8'd31, 1'b0, 1'b1, CLOSE_MARKER));
    plan.push_back(item_row(8'd127, 1'b1, 1'b1, CLOSE_MARKER));
    plan.push_back(reg_row(REG_DIRECTION, 64'hffff_ffff_ffff_ffff));
    plan.push_back(reg_row(REG_KEY_CHARS, 64'h0000_0000_6162_6364));
    plan.push_back(item_row("w", 1'b0));
    plan.push_back(item_row("x", 1'b1));
    plan.push_back(reg_row(REG_UNUSED, 64'hffff_ffff_ffff_ffff));
    plan.push_back(item_row("y", 1'b0));
    // new key with a partial block held, all characters tied
    plan.push_back(reg_row(REG_KEY_CHARS, 64'h0000_0000_6161_6161));
    plan.push_back(item_row("z", 1'b0));
    plan.push_back(item_row(8'h80, 1'b0));
    // zero length acts as one
    plan.push_back(reg_row(REG_KEY_LENGTH, 64'h0));
    plan.push_back(item_row("Q", 1'b0, 1'b1, {8'h51, 1'b1, 1'b1, 1'b0}));
    plan.push_back(item_row("R", 1'b1, 1'b1, {8'h52, 1'b1, 1'b1, 1'b1}));
    // length above the maximum acts as eight, key with extreme and repeated bytes
    plan.push_back(reg_row(REG_KEY_LENGTH, 64'hf));
    plan.push_back(reg_row(REG_KEY_CHARS, 64'hff00_4141_7e20_ff00));
    plan.push_back(reg_row(REG_DIRECTION, 64'h0));
    for (int j = 0; j < MAX_KEY_LEN_DEF; j++) plan.push_back(item_row(8'(8'h30 + j), 1'b0));

    key_now = KEY_CHARS_RESET;
    len_now = KEY_LENGTH_RESET;
    dir_now = 1'b0;
    held = 0;
    for (int j = 0; j < MAX_KEY_LEN_DEF; j++) block_chars[j] = '0;
    rank_key();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].idx, plan[i].data);
      else send_request(plan[i].req, plan[i].typed, plan[i].want);
    end

    // random laps, each under its own key setting
    for (int lap = 0; lap < LAPS; lap++) begin
      quiet_spell = (lap == 2) || ($urandom_range(0, 3) == 0);

      if (lap < 4 || $urandom_range(0, 2) != 0) begin
        case (lap)
          0: len_pick = 4'd8;
          1: len_pick = 4'd1;
          2: len_pick = 4'd0;
          3: len_pick = LEN_W'($urandom_range(9, 15));
          default: len_pick = LEN_W'($urandom_range(1, 8));
        endcase
        fill = {$urandom, $urandom};
        fill[LEN_W-1:0] = len_pick;
        write_reg(REG_KEY_LENGTH, fill);
      end

      if (lap == 0) fill = '0;
      else if (lap == 1) fill = '1;
      else if ($urandom_range(0, 1) == 0) begin
        // narrow alphabet so ties are common
        for (int j = 0; j < MAX_KEY_LEN_DEF; j++) fill[j*8 +: 8] = 8'($urandom_range(97, 100));
      end else fill = {$urandom, $urandom};
      write_reg(REG_KEY_CHARS, fill);

      fill = {$urandom, $urandom};
      fill[0] = (lap == 0) ? 1'b1 : (lap == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      write_reg(REG_DIRECTION, fill);

      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});

      lap_items = ITEMS_PER_LAP;
      for (int i = 0; i < lap_items; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
          r.symbol = 8'($urandom_range(PRINT_LO, PRINT_HI));
          r.end_of_message = ($urandom_range(0, 9) == 0);
        end else if (roll < 92) begin
          r.symbol = ($urandom_range(0, 3) == 0) ? 8'd127 : 8'($urandom_range(0, 31));
          r.end_of_message = 1'($urandom_range(0, 1));
        end else begin
          r.symbol = 8'($urandom_range(128, 255));
          r.end_of_message = 1'($urandom_range(0, 1));
        end
        send_request(r);
        // sender holds back until the block has caught up
        if ((lap == 5 && i == lap_items / 2) || $urandom_range(0, 49) == 0) drain_results();
      end
    end

    r.symbol = CLOSE_BYTE;
    r.end_of_message = 1'b0;
    send_request(r);
    drain_results();

    $display("%0d requests and %0d characters checked across %0d register writes,",
             requests_sent, results_seen, writes_done);
    $display("key lengths 1 to 8 with clamped values, both directions, ties and markers");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/kbtc_pkg.sv
sv/kbtc_ctrl.sv
sv/kbtc_datapath.sv
sv/keyed_block_transposition_cipher.sv
sv/kbtc_checker.sv
tb/keyed_block_transposition_cipher_test.sv
